// ===== sv/seconds_to_calendar_date_top_defines.svh =====
// assertion macros shared by the seconds to calendar date block
// no dependencies; included by the files that carry assertions
`ifndef SECONDS_TO_CALENDAR_DATE_TOP_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_TOP_DEFINES_SVH

// same-cycle implication under reset
`define S2CD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2cd assertion failed");

// next-cycle implication under reset
`define S2CD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2cd assertion failed");

`endif

// ===== sv/s2cd_pkg.sv =====
// types, constants and calendar helper functions for the seconds to calendar date block
// no dependencies; used by s2cd_ctrl, s2cd_dp and the top level
package s2cd_pkg;

    localparam int unsigned SECS_W = 32;
    localparam int unsigned DAYS_W = 16;
    localparam int unsigned YEAR_W = 12;
    localparam int unsigned MON_W = 4;
    localparam int unsigned DAY_W = 5;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W = 6;
    localparam int unsigned SEC_W = 6;
    localparam int unsigned WDAY_W = 3;

    localparam logic [SECS_W-1:0] SECS_PER_DAY = 32'd86400;
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [SECS_W-1:0] SECS_PER_MIN = 32'd60;
    localparam logic [SECS_W-1:0] LIMIT_SECONDS = 32'd4102444800;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1900;
    localparam logic [YEAR_W-1:0] NON_LEAP_CENTURY = 12'd2100;
    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP = 9'd366;
    localparam logic [MON_W-1:0] LAST_MONTH = 4'd11;
    localparam logic [MON_W-1:0] MARCH = 4'd2;

    // reciprocal division: q = ((x >> PRE) * RECIP) >> POST, exact over each step's range
    localparam int unsigned DAY_PRE = 7;
    localparam int unsigned DAY_POST = 35;
    localparam int unsigned DAY_PROD_W = 51;
    localparam logic [DAY_PROD_W-1:0] DAY_RECIP = 51'd50903317;
    localparam int unsigned HOUR_PRE = 4;
    localparam int unsigned HOUR_POST = 21;
    localparam int unsigned HOUR_X_W = 13;
    localparam int unsigned HOUR_PROD_W = 27;
    localparam logic [HOUR_PROD_W-1:0] HOUR_RECIP = 27'd9321;
    localparam int unsigned MIN_PRE = 2;
    localparam int unsigned MIN_POST = 14;
    localparam int unsigned MIN_X_W = 10;
    localparam int unsigned MIN_PROD_W = 21;
    localparam logic [MIN_PROD_W-1:0] MIN_RECIP = 21'd1093;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DIV_DAY,
        OP_REM_DAY,
        OP_DIV_HOUR,
        OP_REM_HOUR,
        OP_DIV_MIN,
        OP_REM_MIN,
        OP_YEAR,
        OP_MONTH,
        OP_CAPTURE
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY,
        ST_DAY_REM,
        ST_HOUR,
        ST_HOUR_REM,
        ST_MIN,
        ST_MIN_REM,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic oor;
        logic year_done;
        logic month_done;
    } dp_status_t;

    typedef struct packed {
        logic              out_of_range;
        logic [WDAY_W-1:0] weekday;
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day_of_month;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } result_t;

    // valid for 1970..2100
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        return (year[1:0] == 2'd0) && (year != NON_LEAP_CENTURY);
    endfunction

    // month index from 0
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (mon)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                     len = 5'd30;
            4'd1:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wk_offset(input logic [MON_W-1:0] mon);
        logic [2:0] off;
        case (mon)
            4'd0:    off = 3'd0;
            4'd1:    off = 3'd3;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd6;
            4'd4:    off = 3'd1;
            4'd5:    off = 3'd4;
            4'd6:    off = 3'd6;
            4'd7:    off = 3'd2;
            4'd8:    off = 3'd5;
            4'd9:    off = 3'd0;
            4'd10:   off = 3'd3;
            4'd11:   off = 3'd5;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // octal digit folding, since 8 is 1 mod 7
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    // mon from 0, day from 1, year 1970..2099
    function automatic logic [WDAY_W-1:0] weekday_of(input logic [YEAR_W-1:0] year,
                                                     input logic [MON_W-1:0] mon,
                                                     input logic [DAY_W-1:0] day);
        logic [7:0] yy;
        logic [8:0] sum;
        yy = 8'(year - BASE_YEAR);
        sum = 9'(yy) + 9'(yy[7:2]) + 9'(day) + 9'(wk_offset(mon));
        if ((yy[1:0] == 2'd0) && (mon < MARCH))
            sum = sum - 9'd1;
        return mod7(sum);
    endfunction

endpackage

// ===== sv/s2cd_ctrl.sv =====
// controller state machine: sequences division, year walk, month walk and output
// depends on s2cd_pkg and seconds_to_calendar_date_top_defines.svh
`include "seconds_to_calendar_date_top_defines.svh"

module s2cd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  s2cd_pkg::dp_status_t status,
    output s2cd_pkg::dp_cmd_t    cmd
);

    s2cd_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= s2cd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            s2cd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = s2cd_pkg::ST_DAY;
            end
            s2cd_pkg::ST_DAY:
            begin
                if (status.oor)
                    state_next = s2cd_pkg::ST_FINISH;
                else
                    state_next = s2cd_pkg::ST_DAY_REM;
            end
            s2cd_pkg::ST_DAY_REM:
                state_next = s2cd_pkg::ST_HOUR;
            s2cd_pkg::ST_HOUR:
                state_next = s2cd_pkg::ST_HOUR_REM;
            s2cd_pkg::ST_HOUR_REM:
                state_next = s2cd_pkg::ST_MIN;
            s2cd_pkg::ST_MIN:
                state_next = s2cd_pkg::ST_MIN_REM;
            s2cd_pkg::ST_MIN_REM:
                state_next = s2cd_pkg::ST_YEAR;
            s2cd_pkg::ST_YEAR:
            begin
                if (status.year_done)
                    state_next = s2cd_pkg::ST_MONTH;
            end
            s2cd_pkg::ST_MONTH:
            begin
                if (status.month_done)
                    state_next = s2cd_pkg::ST_FINISH;
            end
            s2cd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = s2cd_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = s2cd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op   = s2cd_pkg::OP_IDLE;
        s_tready = 1'b0;
        unique case (state_reg)
            s2cd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    cmd.op = s2cd_pkg::OP_LOAD;
            end
            s2cd_pkg::ST_DAY:
            begin
                if (!status.oor)
                    cmd.op = s2cd_pkg::OP_DIV_DAY;
            end
            s2cd_pkg::ST_DAY_REM:
                cmd.op = s2cd_pkg::OP_REM_DAY;
            s2cd_pkg::ST_HOUR:
                cmd.op = s2cd_pkg::OP_DIV_HOUR;
            s2cd_pkg::ST_HOUR_REM:
                cmd.op = s2cd_pkg::OP_REM_HOUR;
            s2cd_pkg::ST_MIN:
                cmd.op = s2cd_pkg::OP_DIV_MIN;
            s2cd_pkg::ST_MIN_REM:
                cmd.op = s2cd_pkg::OP_REM_MIN;
            s2cd_pkg::ST_YEAR:
            begin
                if (!status.year_done)
                    cmd.op = s2cd_pkg::OP_YEAR;
            end
            s2cd_pkg::ST_MONTH:
            begin
                if (!status.month_done)
                    cmd.op = s2cd_pkg::OP_MONTH;
            end
            s2cd_pkg::ST_FINISH:
            begin
                if (out_free)
                    cmd.op = s2cd_pkg::OP_CAPTURE;
            end
            default:
                cmd.op = s2cd_pkg::OP_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

    `S2CD_ASSERT_NEXT(a_accept_starts_day, clk, rst_n, s_tvalid && s_tready,
                      state_reg == s2cd_pkg::ST_DAY)
    `S2CD_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.op == s2cd_pkg::OP_CAPTURE,
                      !out_valid_reg || m_tready)
    `S2CD_ASSERT_NEXT(a_capture_shows, clk, rst_n, cmd.op == s2cd_pkg::OP_CAPTURE,
                      out_valid_reg && state_reg == s2cd_pkg::ST_IDLE)
    `S2CD_ASSERT_NEXT(a_oor_skips, clk, rst_n, state_reg == s2cd_pkg::ST_DAY && status.oor,
                      state_reg == s2cd_pkg::ST_FINISH)

endmodule

// ===== sv/s2cd_dp.sv =====
// datapath: reciprocal dividers, year and month walk registers, result register
// depends on s2cd_pkg
module s2cd_dp (
    input  logic                              clk,
    input  s2cd_pkg::dp_cmd_t                 cmd,
    input  logic [s2cd_pkg::SECS_W-1:0]       seconds_count,
    output s2cd_pkg::dp_status_t              status,
    output s2cd_pkg::result_t                 result
);

    logic [s2cd_pkg::SECS_W-1:0] rem_reg, rem_next;
    logic [s2cd_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [s2cd_pkg::HOUR_W-1:0] hour_reg, hour_next;
    logic [s2cd_pkg::MIN_W-1:0]  minute_reg, minute_next;
    logic [s2cd_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [s2cd_pkg::MON_W-1:0]  mon_reg, mon_next;
    logic                        oor_reg, oor_next;
    s2cd_pkg::result_t           res_reg, res_next;

    logic [s2cd_pkg::DAY_PROD_W-1:0]  day_prod;
    logic [s2cd_pkg::HOUR_PROD_W-1:0] hour_prod;
    logic [s2cd_pkg::MIN_PROD_W-1:0]  min_prod;
    logic                        leap;
    logic [8:0]                  ylen;
    logic [s2cd_pkg::DAY_W-1:0]  mlen;

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        oor_reg    <= oor_next;
        res_reg    <= res_next;
    end

    assign day_prod  = s2cd_pkg::DAY_PROD_W'(rem_reg[s2cd_pkg::SECS_W-1:s2cd_pkg::DAY_PRE])
                       * s2cd_pkg::DAY_RECIP;
    assign hour_prod = s2cd_pkg::HOUR_PROD_W'(rem_reg[s2cd_pkg::HOUR_PRE +: s2cd_pkg::HOUR_X_W])
                       * s2cd_pkg::HOUR_RECIP;
    assign min_prod  = s2cd_pkg::MIN_PROD_W'(rem_reg[s2cd_pkg::MIN_PRE +: s2cd_pkg::MIN_X_W])
                       * s2cd_pkg::MIN_RECIP;

    assign leap = s2cd_pkg::is_leap(year_reg);
    assign ylen = leap ? s2cd_pkg::DAYS_LEAP : s2cd_pkg::DAYS_COMMON;
    assign mlen = s2cd_pkg::month_days(mon_reg, leap);

    assign status.oor        = oor_reg;
    assign status.year_done  = days_reg < s2cd_pkg::DAYS_W'(ylen);
    assign status.month_done = (mon_reg == s2cd_pkg::LAST_MONTH)
                               || (days_reg < s2cd_pkg::DAYS_W'(mlen));

    always_comb
    begin
        rem_next    = rem_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        oor_next    = oor_reg;
        res_next    = res_reg;
        unique case (cmd.op)
            s2cd_pkg::OP_IDLE:
            begin
                res_next = res_reg;
            end
            s2cd_pkg::OP_LOAD:
            begin
                rem_next    = seconds_count;
                days_next   = '0;
                hour_next   = '0;
                minute_next = '0;
                year_next   = s2cd_pkg::EPOCH_YEAR;
                mon_next    = '0;
                oor_next    = seconds_count >= s2cd_pkg::LIMIT_SECONDS;
            end
            s2cd_pkg::OP_DIV_DAY:
                days_next = day_prod[s2cd_pkg::DAY_POST +: s2cd_pkg::DAYS_W];
            s2cd_pkg::OP_REM_DAY:
                rem_next = rem_reg - (s2cd_pkg::SECS_W'(days_reg) * s2cd_pkg::SECS_PER_DAY);
            s2cd_pkg::OP_DIV_HOUR:
                hour_next = hour_prod[s2cd_pkg::HOUR_POST +: s2cd_pkg::HOUR_W];
            s2cd_pkg::OP_REM_HOUR:
                rem_next = rem_reg - (s2cd_pkg::SECS_W'(hour_reg) * s2cd_pkg::SECS_PER_HOUR);
            s2cd_pkg::OP_DIV_MIN:
                minute_next = min_prod[s2cd_pkg::MIN_POST +: s2cd_pkg::MIN_W];
            s2cd_pkg::OP_REM_MIN:
                rem_next = rem_reg - (s2cd_pkg::SECS_W'(minute_reg) * s2cd_pkg::SECS_PER_MIN);
            s2cd_pkg::OP_YEAR:
            begin
                days_next = days_reg - s2cd_pkg::DAYS_W'(ylen);
                year_next = year_reg + 1'b1;
            end
            s2cd_pkg::OP_MONTH:
            begin
                days_next = days_reg - s2cd_pkg::DAYS_W'(mlen);
                mon_next  = mon_reg + 1'b1;
            end
            s2cd_pkg::OP_CAPTURE:
            begin
                if (oor_reg)
                begin
                    res_next              = '0;
                    res_next.out_of_range = 1'b1;
                end
                else
                begin
                    res_next.out_of_range = 1'b0;
                    res_next.year         = year_reg;
                    res_next.month        = mon_reg + 1'b1;
                    res_next.day_of_month = days_reg[s2cd_pkg::DAY_W-1:0] + 1'b1;
                    res_next.hour         = hour_reg;
                    res_next.minute       = minute_reg;
                    res_next.second       = rem_reg[s2cd_pkg::SEC_W-1:0];
                    res_next.weekday      = s2cd_pkg::weekday_of(year_reg, mon_reg,
                                                days_reg[s2cd_pkg::DAY_W-1:0] + 1'b1);
                end
            end
            default:
                res_next = res_reg;
        endcase
    end

    assign result = res_reg;

endmodule

// ===== sv/seconds_to_calendar_date_top.sv =====
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year, month, day,
// hour, minute, second and weekday (0 is Sunday); counts past 2099-12-31 23:59:59 give
// out_of_range with all other fields zero. One item is worked on at a time. The steps
// are reciprocal division and remainder for days, hours and minutes, then the year walk
// and the month walk, which step through the years and months until the day count fits,
// then the capture; a count out of range goes from the day step straight to the capture.
// A finished result waits in an output register, so the next item can be accepted
// before the last one is taken; a result still waiting holds the next one at its
// capture step.
// depends on s2cd_pkg, s2cd_ctrl and s2cd_dp
module seconds_to_calendar_date_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // seconds_count
    output logic        m_tvalid,
    input  logic        m_tready,
    // year, month, day_of_month, hour, minute, second, weekday, zero fill
    output logic [47:0] m_tdata,
    output logic        m_tuser    // out_of_range
);

    s2cd_pkg::dp_cmd_t    cmd;
    s2cd_pkg::dp_status_t status;
    s2cd_pkg::result_t    result;

    s2cd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    s2cd_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .seconds_count (s_tdata),
        .status        (status),
        .result        (result)
    );

    assign m_tdata = {7'd0, result.weekday, result.second, result.minute, result.hour,
                      result.day_of_month, result.month, result.year};
    assign m_tuser = result.out_of_range;

endmodule

// ===== tb/seconds_to_calendar_date_top_tb.sv =====
// Self-checking testbench for seconds_to_calendar_date_top: directed table, then random counts
// with idle bursts on both streams; checked vs typed rows or an in-bench calendar predictor.
// depends on s2cd_pkg (result_t) and seconds_to_calendar_date_top
module seconds_to_calendar_date_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef s2cd_pkg::result_t result_t;

    localparam logic [31:0] FIRST_BEYOND_2099 = 32'd4102444800;
    localparam int unsigned RANDOM_ITEMS = 1930;
    localparam int unsigned CALM_ITEMS = 200;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned WEEK_SHIFT [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    typedef struct {
        logic [31:0] secs;
        bit          typed;
        result_t     want;
    } date_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    result_t     pending_dates [$];
    int unsigned mismatches = 0;
    bit          calm = 1'b0;

    seconds_to_calendar_date_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic result_t calendar_of(input logic [31:0] secs);
        result_t     r;
        int unsigned days;
        int unsigned rem;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        int unsigned yy;
        int unsigned t;
        r = '0;
        if (secs >= FIRST_BEYOND_2099)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        days = secs / 86400;
        rem = secs % 86400;
        yr = 1970;
        forever
        begin
            len = leap_year(yr) ? 366 : 365;
            if (days < len)
                break;
            days -= len;
            yr++;
        end
        mon = 0;
        while (mon < 11)
        begin
            len = MONTH_LEN[mon];
            if (mon == 1 && leap_year(yr))
                len = 29;
            if (days < len)
                break;
            days -= len;
            mon++;
        end
        yy = yr % 100;
        if (yr / 100 > 19)
            yy += 100;
        t = (yy + yy / 4) % 7;
        t = t + days + 1 + WEEK_SHIFT[mon];
        if (yy % 4 == 0 && mon < 2)
            t -= 1;
        r.year = 12'(yr);
        r.month = 4'(mon + 1);
        r.day_of_month = 5'(days + 1);
        r.hour = 5'(rem / 3600);
        r.minute = 6'((rem % 3600) / 60);
        r.second = 6'(rem % 60);
        r.weekday = 3'(t % 7);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // one item in, expectation queued at acceptance; entered and left at a falling edge
    task automatic send_secs(input logic [31:0] secs, input result_t want);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tdata <= secs;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_dates.push_back(want);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.year = m_tdata[11:0];
            got.month = m_tdata[15:12];
            got.day_of_month = m_tdata[20:16];
            got.hour = m_tdata[25:21];
            got.minute = m_tdata[31:26];
            got.second = m_tdata[37:32];
            got.weekday = m_tdata[40:38];
            got.out_of_range = m_tuser;
            if (pending_dates.size() == 0)
            begin
                $error("result item with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("year", want.year, got.year);
                check_field("month", want.month, got.month);
                check_field("day_of_month", want.day_of_month, got.day_of_month);
                check_field("hour", want.hour, got.hour);
                check_field("minute", want.minute, got.minute);
                check_field("second", want.second, got.second);
                check_field("weekday", want.weekday, got.weekday);
                check_field("out_of_range", want.out_of_range, got.out_of_range);
            end
        end
    end

    // result side back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        date_row_t   date_rows [20];
        int unsigned yr;
        int unsigned days;
        int unsigned pick;
        logic [31:0] secs;

        date_rows = '{
            '{32'd0, 1'b1, result_t'{year: 12'd1970, month: 4'd1, day_of_month: 5'd1,
                                     hour: 5'd0, minute: 6'd0, second: 6'd0,
                                     weekday: 3'd4, out_of_range: 1'b0}},
            '{32'd59, 1'b0, result_t'('0)},
            '{32'd60, 1'b0, result_t'('0)},
            '{32'd3599, 1'b0, result_t'('0)},
            '{32'd3600, 1'b0, result_t'('0)},
            '{32'd86399, 1'b0, result_t'('0)},
            '{32'd86400, 1'b0, result_t'('0)},
            // leap day and last day of a leap year
            '{32'd68169600, 1'b0, result_t'('0)},
            '{32'd94608000, 1'b0, result_t'('0)},
            '{32'd94694399, 1'b0, result_t'('0)},
            '{32'd94694400, 1'b0, result_t'('0)},
            '{32'd946684800, 1'b0, result_t'('0)},
            '{32'd951782400, 1'b0, result_t'('0)},
            '{32'd978220800, 1'b0, result_t'('0)},
            '{32'h7FFF_FFFF, 1'b0, result_t'('0)},
            '{32'h8000_0000, 1'b0, result_t'('0)},
            '{32'h5555_5555, 1'b0, result_t'('0)},
            '{32'd4102444799, 1'b1, result_t'{year: 12'd2099, month: 4'd12, day_of_month: 5'd31,
                                             hour: 5'd23, minute: 6'd59, second: 6'd59,
                                             weekday: 3'd4, out_of_range: 1'b0}},
            '{FIRST_BEYOND_2099, 1'b1, result_t'{out_of_range: 1'b1, default: '0}},
            '{32'hFFFF_FFFF, 1'b1, result_t'{out_of_range: 1'b1, default: '0}}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (date_rows[i])
            send_secs(date_rows[i].secs,
                      date_rows[i].typed ? date_rows[i].want : calendar_of(date_rows[i].secs));
        send_secs(32'hAAAA_AAAA, calendar_of(32'hAAAA_AAAA));

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                secs = $urandom_range(32'd4102444799, 32'd0);
            else if (pick == 7)
                secs = $urandom_range(32'hFFFF_FFFF, FIRST_BEYOND_2099);
            else
            begin
                // around year ends, leap days and midnight
                yr = $urandom_range(2099, 1970);
                days = 0;
                for (int unsigned y = 1970; y < yr; y++)
                    days += leap_year(y) ? 366 : 365;
                case ($urandom_range(0, 4))
                    0: days += 0;
                    1: days += 58;
                    2: days += 59;
                    3: days += 364;
                    default: days += 365;
                endcase
                case ($urandom_range(0, 2))
                    0: secs = days * 86400;
                    1: secs = days * 86400 + 86399;
                    default: secs = days * 86400 + $urandom_range(86399, 0);
                endcase
            end
            send_secs(secs, calendar_of(secs));
        end
        s_tvalid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== seconds_to_calendar_date_top.f =====
+incdir+sv
sv/s2cd_pkg.sv
sv/s2cd_ctrl.sv
sv/s2cd_dp.sv
sv/seconds_to_calendar_date_top.sv
tb/seconds_to_calendar_date_top_tb.sv
